[design/bft_pkg.sv]
// Shared constants and types of the best-fit free block table.
package bft_pkg;

    localparam int ENTRIES     = 64;
    localparam int SIZE_BITS   = 32;
    localparam int OFFSET_BITS = 40;
    localparam int ENTRY_W     = SIZE_BITS + OFFSET_BITS;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int CAP_W       = 7;
    localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // One table slot presented to the best-fit tracker.
    typedef struct packed {
        logic             start;
        logic             sample;
        logic [IDX_W-1:0] idx;
        logic             entry_valid;
    } probe_t;

    // Running result of a scan: best fitting slot and lowest free slot.
    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       idx;
        logic [SIZE_BITS-1:0]   size;
        logic [OFFSET_BITS-1:0] offset;
        logic                   free_found;
        logic [IDX_W-1:0]       free_idx;
    } best_t;

endpackage

[design/best_fit_free_block_table.sv]
// Best-fit free block table: slots in a RAM, scanned one slot per cycle.
//
// Input channel (in_valid/in_ready): op selects insert (0) or best-fit search (1).
// An insert stores req_size/req_offset in the lowest free slot; a full table
// first evicts its smallest block and returns it with found set. A search
// returns and removes the smallest block of at least req_size, ties going to
// the lowest offset, then the lowest slot. An insert of size zero does nothing.
// Output channel (out_valid/out_ready) carries exactly one item per input item.
// Each item is accepted in ST_IDLE, issues one read of the slot RAM per cycle
// over the capacity in use, waits for the registered read of the last slot,
// and writes back in ST_DONE. An insert of size zero skips the scan.
// Items are handled one at a time; the next item is accepted while the last
// result still waits in the output register, and a stalled receiver holds the
// block only when the next result is ready to be written.
// Reset empties the table (valid bits and slot count clear at once) and sets
// capacity to 64. Writing capacity empties the table the same way; write it
// only while the block is idle.
module best_fit_free_block_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bft_pkg::CAP_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [bft_pkg::SIZE_BITS-1:0]     req_size,
    input  logic [bft_pkg::OFFSET_BITS-1:0]   req_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [bft_pkg::SIZE_BITS-1:0]     out_size,
    output logic [bft_pkg::OFFSET_BITS-1:0]   out_offset
);

    import bft_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    state_t                 state_reg, state_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]       issue_reg, issue_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   op_reg;
    logic [SIZE_BITS-1:0]   size_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic                   noop_reg;
    logic                   full_reg;
    logic                   found_reg;
    logic [SIZE_BITS-1:0]   out_size_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;

    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic [IDX_W-1:0]       cap_last;
    logic                   full;
    logic                   accept;
    logic                   rd_en;
    logic [ENTRY_W-1:0]     rd_data;
    logic [SIZE_BITS-1:0]   min_size;
    probe_t                 probe;
    best_t                  best;
    logic                   out_free;
    logic                   commit;
    logic                   take;
    logic                   put;
    logic [IDX_W-1:0]       slot;

    // Capacity in use, clamped to 1..ENTRIES.
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign cap_last = IDX_W'(eff_cap - CMP_W'(1));
    assign full     = CMP_W'(used_reg) >= eff_cap;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_en    = (state_reg == ST_SCAN) && !issue_done_reg;
    assign min_size = (op_reg == OP_SEARCH) ? size_reg : '0;

    assign probe.start       = accept;
    assign probe.sample      = chk_vld_reg;
    assign probe.idx         = chk_idx_reg;
    assign probe.entry_valid = valid_reg[chk_idx_reg];

    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == ST_DONE) && out_free;
    assign take     = !noop_reg && best.found && ((op_reg == OP_SEARCH) || full_reg);
    assign put      = !noop_reg && (op_reg == OP_INSERT);
    // A full table reuses the slot just evicted; otherwise the lowest free one.
    assign slot     = full_reg ? best.idx : best.free_idx;

    bft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (commit && put),
        .waddr (slot),
        .wdata ({size_reg, off_reg}),
        .re    (rd_en),
        .raddr (issue_reg),
        .rdata (rd_data)
    );

    bft_best u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .probe    (probe),
        .min_size (min_size),
        .rd_data  (rd_data),
        .best     (best)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op == OP_INSERT) && (req_size == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg && (chk_idx_reg == cap_last))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The compare stage checks each slot in the cycle after its read is issued.
    always_comb
    begin
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = rd_en;
        if (accept)
        begin
            issue_next      = '0;
            issue_done_next = 1'b0;
        end
        else if (rd_en)
        begin
            if (issue_reg == cap_last)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                issue_next = issue_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        cap_next   = cap_reg;
        valid_next = valid_reg;
        used_next  = used_reg;
        if (cfg_wr_en)
        begin
            cap_next   = cfg_wr_data;
            valid_next = '0;
            used_next  = '0;
        end
        else if (commit)
        begin
            if (take)
            begin
                valid_next[best.idx] = 1'b0;
            end
            if (put)
            begin
                valid_next[slot] = 1'b1;
            end
            if (put && !full_reg)
            begin
                used_next = used_reg + CNT_W'(1);
            end
            else if (take && (op_reg == OP_SEARCH))
            begin
                used_next = used_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            used_reg       <= '0;
            valid_reg      <= '0;
            issue_reg      <= '0;
            issue_done_reg <= 1'b1;
            chk_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            used_reg       <= used_next;
            valid_reg      <= valid_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= issue_reg;
        if (accept)
        begin
            op_reg   <= op;
            size_reg <= req_size;
            off_reg  <= req_offset;
            noop_reg <= (op == OP_INSERT) && (req_size == '0);
            full_reg <= full;
        end
        if (commit)
        begin
            found_reg      <= take;
            out_size_reg   <= take ? best.size : '0;
            out_offset_reg <= take ? best.offset : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign out_size   = out_size_reg;
    assign out_offset = out_offset_reg;

    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(used_reg))
        else $error("slot count disagrees with valid bits");

    a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !noop_reg && op_reg == OP_INSERT && full_reg)
        |-> best.found)
        else $error("full table insert found nothing to evict");

    a_free_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !noop_reg && op_reg == OP_INSERT && !full_reg)
        |-> best.free_found)
        else $error("insert into a table with room found no free slot");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && chk_vld_reg) |-> (chk_idx_reg <= cap_last))
        else $error("scan ran past the capacity in use");

endmodule

[design/bft_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/bft_best.sv]
// Best-fit tracker: compares each scanned slot against the best one so far.
module bft_best (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bft_pkg::probe_t                 probe,
    input  logic [bft_pkg::SIZE_BITS-1:0]   min_size,
    input  logic [bft_pkg::ENTRY_W-1:0]     rd_data,
    output bft_pkg::best_t                  best
);

    import bft_pkg::*;

    best_t                  best_reg;
    best_t                  best_next;
    logic [SIZE_BITS-1:0]   ent_size;
    logic [OFFSET_BITS-1:0] ent_off;
    logic                   fits;
    logic                   better;

    assign ent_size = rd_data[ENTRY_W-1:OFFSET_BITS];
    assign ent_off  = rd_data[OFFSET_BITS-1:0];
    assign fits     = probe.entry_valid && (ent_size >= min_size);

    // Strict compares keep the earlier slot on a full tie, so the lowest slot wins.
    assign better = !best_reg.found || (ent_size < best_reg.size) ||
                    ((ent_size == best_reg.size) && (ent_off < best_reg.offset));

    always_comb
    begin
        best_next = best_reg;
        if (probe.start)
        begin
            best_next.found      = 1'b0;
            best_next.free_found = 1'b0;
        end
        else if (probe.sample)
        begin
            if (fits && better)
            begin
                best_next.found  = 1'b1;
                best_next.idx    = probe.idx;
                best_next.size   = ent_size;
                best_next.offset = ent_off;
            end
            if (!probe.entry_valid && !best_reg.free_found)
            begin
                best_next.free_found = 1'b1;
                best_next.free_idx   = probe.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

[test/bft_tb_pkg.sv]
// Request codes and the reply record shared by the free block table testbench.
package bft_tb_pkg;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } table_op_e;

    typedef struct packed {
        logic                            found;
        logic [bft_pkg::SIZE_BITS-1:0]   size;
        logic [bft_pkg::OFFSET_BITS-1:0] offset;
    } block_reply_t;

endpackage

[test/bft_checker.sv]
// Watches both channels of the free block table, tracks its contents and checks every reply.
module bft_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bft_pkg::CAP_W-1:0]       cfg_wr_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            op,
    input  logic [bft_pkg::SIZE_BITS-1:0]   req_size,
    input  logic [bft_pkg::OFFSET_BITS-1:0] req_offset,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            found,
    input  logic [bft_pkg::SIZE_BITS-1:0]   out_size,
    input  logic [bft_pkg::OFFSET_BITS-1:0] out_offset,
    output int                              fail_count,
    output int                              waiting,
    output int                              reply_count,
    output int                              hit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bft_pkg::*;
    import bft_tb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [CAP_W-1:0]       capacity;
    logic                   slot_used   [ENTRIES];
    logic [SIZE_BITS-1:0]   slot_size   [ENTRIES];
    logic [OFFSET_BITS-1:0] slot_offset [ENTRIES];
    int                     used_slots;
    block_reply_t           awaited_replies [$];

    function automatic int active_slots();
        int c;
        c = int'(capacity);
        if (c == 0)
            c = 1;
        if (c > ENTRIES)
            c = ENTRIES;
        return c;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_used[i]   = 1'b0;
            slot_size[i]   = '0;
            slot_offset[i] = '0;
        end
        used_slots = 0;
    endfunction

    // Smallest stored block of at least min_size; equal sizes go to the lower offset,
    // then to the lower slot. Returns -1 when nothing fits.
    function automatic int best_fit(logic [SIZE_BITS-1:0] min_size);
        int best;
        best = -1;
        for (int i = 0; i < active_slots(); i++)
        begin
            if (slot_used[i] && slot_size[i] >= min_size)
            begin
                if (best < 0 || slot_size[i] < slot_size[best] ||
                    (slot_size[i] == slot_size[best] && slot_offset[i] < slot_offset[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic block_reply_t release_slot(int s);
        block_reply_t r;
        r.found  = 1'b1;
        r.size   = slot_size[s];
        r.offset = slot_offset[s];
        slot_used[s] = 1'b0;
        slot_size[s] = '0;
        if (used_slots > 0)
            used_slots--;
        return r;
    endfunction

    function automatic block_reply_t serve_request(table_op_e kind,
                                                   logic [SIZE_BITS-1:0] size,
                                                   logic [OFFSET_BITS-1:0] offset);
        block_reply_t r;
        int           s;
        int           lim;
        r   = '0;
        lim = active_slots();
        if (kind == OP_SEARCH)
        begin
            s = best_fit(size);
            if (s >= 0)
                r = release_slot(s);
        end
        else if (size != '0)
        begin
            // A full table gives up its smallest block to make room.
            if (used_slots >= lim)
            begin
                s = best_fit('0);
                if (s >= 0)
                    r = release_slot(s);
            end
            for (int i = 0; i < lim; i++)
            begin
                if (!slot_used[i])
                begin
                    slot_used[i]   = 1'b1;
                    slot_size[i]   = size;
                    slot_offset[i] = offset;
                    used_slots++;
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        block_reply_t want;
        block_reply_t got;
        block_reply_t next_reply;
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            empty_table();
            awaited_replies.delete();
            fail_count  = 0;
            reply_count = 0;
            hit_count   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity = cfg_wr_data;
                empty_table();
            end
            // Replies are checked before the new item is queued, so a reply can
            // never be matched against the item accepted at the same edge.
            if (out_valid && out_ready)
            begin
                got.found  = found;
                got.size   = out_size;
                got.offset = out_offset;
                reply_count++;
                if (got.found === 1'b1)
                    hit_count++;
                if (awaited_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: reply with no request waiting: found=%0b size=%h offset=%h",
                                 $realtime, got.found, got.size, got.offset);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.found !== want.found || got.size !== want.size ||
                        got.offset !== want.offset)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: reply mismatch: expected found=%0b size=%h offset=%h",
                                     $realtime, want.found, want.size, want.offset);
                            $display("%0t:                 got found=%0b size=%h offset=%h",
                                     $realtime, got.found, got.size, got.offset);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                next_reply      = serve_request(table_op_e'(op), req_size, req_offset);
                awaited_replies = {awaited_replies, next_reply};
            end
        end
        waiting = awaited_replies.size();
    end

endmodule

[test/tb_top.sv]
// Stimulus, clock, reset and verdict for the best-fit free block table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bft_pkg::*;
    import bft_tb_pkg::*;

    // The limit covers the slowest item plus the longest sender gap and receiver
    // stall, and leaves a wide margin over their sum.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES        = 10;

    localparam int PHASE_CAP        [PHASES] = '{2, 5, 1, 64, 127, 16, 0, 40, 3, 64};
    localparam int PHASE_ITEMS      [PHASES] = '{40, 50, 30, 100, 60, 50, 30, 60, 40, 50};
    localparam int PHASE_INSERT_PCT [PHASES] = '{55, 55, 50, 80, 40, 60, 55, 70, 55, 50};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   op;
    logic [SIZE_BITS-1:0]   req_size;
    logic [OFFSET_BITS-1:0] req_offset;
    logic                   out_valid;
    logic                   out_ready;
    logic                   found;
    logic [SIZE_BITS-1:0]   out_size;
    logic [OFFSET_BITS-1:0] out_offset;

    int fail_count;
    int waiting;
    int reply_count;
    int hit_count;

    bit                   steady;
    int                   requests_sent;
    int                   settings_seen;
    int                   quiet_cycles;
    logic [SIZE_BITS-1:0] recent_sizes [$];

    best_fit_free_block_table i_dut (.*);

    bft_checker i_checker (.*);

    always #2 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] pick_offset();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return OFFSET_BITS'($urandom_range(0, 7));
        return w[OFFSET_BITS-1:0];
    endfunction

    // Small sizes dominate so that equal sizes and duplicates are common.
    function automatic logic [SIZE_BITS-1:0] pick_insert_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 55)
            return SIZE_BITS'($urandom_range(1, 16));
        if (r < 70)
            return SIZE_BITS'($urandom_range(17, 4096));
        if (r < 90)
            return SIZE_BITS'($urandom);
        return {SIZE_BITS{1'b1}} - SIZE_BITS'($urandom_range(0, 3));
    endfunction

    // Searches often ask for a size just stored, so most of them hit.
    function automatic logic [SIZE_BITS-1:0] pick_search_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && recent_sizes.size() > 0)
            return recent_sizes[$urandom_range(0, recent_sizes.size() - 1)] -
                   SIZE_BITS'($urandom_range(0, 1));
        if (r < 60)
            return SIZE_BITS'($urandom_range(0, 16));
        if (r < 70)
            return '0;
        if (r < 85)
            return SIZE_BITS'($urandom);
        return {SIZE_BITS{1'b1}} - SIZE_BITS'($urandom_range(0, 3));
    endfunction

    // Called and returning at a falling edge; valid stays high until the next
    // call or until something else lowers it.
    task automatic send_request(table_op_e kind, logic [SIZE_BITS-1:0] size,
                                logic [OFFSET_BITS-1:0] offset);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        op         = kind;
        req_size   = size;
        req_offset = offset;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        requests_sent++;
        if (kind == OP_INSERT && size != '0)
        begin
            recent_sizes = {recent_sizes, size};
            if (recent_sizes.size() > 16)
                void'(recent_sizes.pop_front());
        end
    endtask

    task automatic settle(int extra);
        in_valid = 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        settle(4);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        settings_seen++;
    endtask

    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = gap_len();
            if (n > 0)
            begin
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        table_op_e kind;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        op            = OP_INSERT;
        req_size      = '0;
        req_offset    = '0;
        steady        = 1'b0;
        requests_sent = 0;
        settings_seen = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, ignored zero-size insert, extreme values, equal sizes,
        // duplicates, a search that fits nothing and a search for size zero.
        send_request(OP_SEARCH, '0, '0);
        send_request(OP_INSERT, '0, '1);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, 1, '0);
        send_request(OP_INSERT, 5, 7);
        send_request(OP_INSERT, 5, 7);
        send_request(OP_INSERT, 5, 3);
        send_request(OP_INSERT, 100, 40'h55_5555_5555);
        send_request(OP_SEARCH, '0, '1);
        send_request(OP_SEARCH, 5, '0);
        send_request(OP_SEARCH, 4, '0);
        send_request(OP_SEARCH, 5, '0);
        send_request(OP_SEARCH, 101, '0);
        send_request(OP_SEARCH, 101, '0);
        send_request(OP_SEARCH, 100, '0);

        // A capacity of zero behaves as one slot: the second insert evicts.
        set_capacity(0);
        send_request(OP_INSERT, 10, 1);
        send_request(OP_INSERT, 20, 2);
        send_request(OP_INSERT, '0, 3);
        send_request(OP_SEARCH, '0, '0);

        // A register write empties the table.
        set_capacity(127);
        send_request(OP_INSERT, 9, 9);
        set_capacity(127);
        send_request(OP_SEARCH, '0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(CAP_W'(PHASE_CAP[p]));
            steady = (p % 3 == 1);
            for (int i = 0; i < PHASE_ITEMS[p]; i++)
            begin
                if ($urandom_range(0, 99) < 4)
                    settle(0);
                if ($urandom_range(0, 99) < PHASE_INSERT_PCT[p])
                    kind = OP_INSERT;
                else
                    kind = OP_SEARCH;
                if (kind == OP_INSERT)
                    send_request(kind, pick_insert_size(), pick_offset());
                else
                    send_request(kind, pick_search_size(), pick_offset());
            end
        end

        steady = 1'b0;
        settle(SETTLE_CYCLES);
        $display("Sent %0d inserts and searches over %0d capacity settings from 0 to 127.",
                 requests_sent, settings_seen);
        $display("Checked %0d replies, %0d of them returning or evicting a block.",
                 reply_count, hit_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
